/* design/sfs_pkg.sv */
// Shared types and constants for the symmetric saturating FIR filter.
package sfs_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 36;
    localparam int OUT_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int NUM_COEF   = 8;
    localparam int CIDX_W     = 3;
    localparam int MAX_LEAVES = 8;

    // Pre-added sample pair, coefficient split and product widths.
    localparam int PRE_W  = SAMPLE_W + 1;
    localparam int CLO_W  = 18;
    localparam int CHI_W  = COEF_W - CLO_W;
    localparam int PLO_W  = PRE_W + CLO_W + 1;
    localparam int PHI_W  = PRE_W + CHI_W;
    localparam int PROD_W = PRE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [OUT_W-1:0]    out_t;
    typedef logic [CIDX_W-1:0]          cidx_t;

    localparam coef_t COEF_RESET [NUM_COEF] = '{
        36'sd4564533,
        -36'sd51335336,
        36'sd282339434,
        -36'sd990152595,
        36'sd2462163746,
        -36'sd4585616450,
        36'sd6591977902,
        -36'sd7427882468
    };

    // Limits of the exact sum (8 fraction bits) that pass without clamping.
    localparam acc_t SUM_MAX    = 72'sd8388352;
    localparam acc_t SUM_MIN    = -72'sd8388608;
    localparam acc_t TRUNC_BIAS = 72'sd255;
    localparam out_t OUT_MAX    = 16'sh7fff;
    localparam out_t OUT_MIN    = 16'sh8000;

    // Load strobes for the sample line and the arithmetic stages of a cell.
    typedef struct packed {
        logic shift;
        logic ld_pre;
        logic ld_part;
        logic ld_prod;
    } cell_ctl_t;

    // Load strobes for the levels of the adder tree.
    typedef struct packed {
        logic ld_l1;
        logic ld_l2;
        logic ld_l3;
    } tree_ctl_t;

endpackage

/* design/sfs_tap_cell.sv */
// One folded tap cell: two delay-line elements (one in the center cell), pre-adder and multiplier.
module sfs_tap_cell #(
    parameter bit SINGLE = 1'b0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sfs_pkg::cell_ctl_t ctl,
    input  sfs_pkg::coef_t    coef,
    input  sfs_pkg::sample_t  a_in,
    input  sfs_pkg::sample_t  b_in,
    output sfs_pkg::sample_t  a_out,
    output sfs_pkg::sample_t  b_out,
    output sfs_pkg::prod_t    prod
);

    sfs_pkg::sample_t                      fwd_reg;
    logic signed [sfs_pkg::PRE_W-1:0]      pre_next;
    logic signed [sfs_pkg::PRE_W-1:0]      pre_reg;
    logic signed [sfs_pkg::CLO_W:0]        c_lo;
    logic signed [sfs_pkg::CHI_W-1:0]      c_hi;
    logic signed [sfs_pkg::PLO_W-1:0]      plo_next;
    logic signed [sfs_pkg::PLO_W-1:0]      plo_reg;
    logic signed [sfs_pkg::PHI_W-1:0]      phi_next;
    logic signed [sfs_pkg::PHI_W-1:0]      phi_reg;
    sfs_pkg::prod_t                        prod_next;
    sfs_pkg::prod_t                        prod_reg;

    // The forward element carries the newer sample of the pair on to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= '0;
        end
        else if (ctl.shift)
        begin
            fwd_reg <= a_in;
        end
    end

    assign a_out = fwd_reg;

    generate
        if (SINGLE)
        begin : g_center
            // The center tap has no partner sample.
            assign pre_next = sfs_pkg::PRE_W'(a_in);
            assign b_out    = a_in;
        end
        else
        begin : g_pair
            sfs_pkg::sample_t bwd_reg;

            // The backward element holds the older sample of the pair.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    bwd_reg <= '0;
                end
                else if (ctl.shift)
                begin
                    bwd_reg <= b_in;
                end
            end

            assign pre_next = sfs_pkg::PRE_W'(a_in) + sfs_pkg::PRE_W'(bwd_reg);
            assign b_out    = bwd_reg;
        end
    endgenerate

    // The coefficient is split so that each multiplier stays near 33 by 18 bits.
    assign c_lo      = $signed({1'b0, coef[sfs_pkg::CLO_W-1:0]});
    assign c_hi      = coef[sfs_pkg::COEF_W-1:sfs_pkg::CLO_W];
    assign plo_next  = sfs_pkg::PLO_W'(pre_reg) * sfs_pkg::PLO_W'(c_lo);
    assign phi_next  = sfs_pkg::PHI_W'(pre_reg) * sfs_pkg::PHI_W'(c_hi);
    assign prod_next = (sfs_pkg::PROD_W'(phi_reg) <<< sfs_pkg::CLO_W)
                       + sfs_pkg::PROD_W'(plo_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.ld_pre)
        begin
            pre_reg <= pre_next;
        end
        if (ctl.ld_part)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (ctl.ld_prod)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

/* design/sfs_sum_tree.sv */
// Registered three-level adder tree that sums the cell products.
module sfs_sum_tree #(
    parameter int NLEAF = 8
) (
    input  logic               clk,
    input  sfs_pkg::tree_ctl_t ctl,
    input  sfs_pkg::prod_t     prod [NLEAF],
    output sfs_pkg::acc_t      sum
);

    localparam int N1 = sfs_pkg::MAX_LEAVES / 2;
    localparam int N2 = sfs_pkg::MAX_LEAVES / 4;

    sfs_pkg::prod_t                        leaf [sfs_pkg::MAX_LEAVES];
    logic signed [sfs_pkg::PROD_W:0]       l1_reg [N1];
    logic signed [sfs_pkg::PROD_W+1:0]     l2_reg [N2];
    sfs_pkg::acc_t                         l3_reg;

    // Leaves beyond the number of cells contribute zero.
    generate
        for (genvar i = 0; i < sfs_pkg::MAX_LEAVES; i++)
        begin : g_leaf
            if (i < NLEAF)
            begin : g_used
                assign leaf[i] = prod[i];
            end
            else
            begin : g_zero
                assign leaf[i] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctl.ld_l1)
        begin
            for (int i = 0; i < N1; i++)
            begin
                l1_reg[i] <= (sfs_pkg::PROD_W+1)'(leaf[2*i])
                             + (sfs_pkg::PROD_W+1)'(leaf[2*i+1]);
            end
        end
        if (ctl.ld_l2)
        begin
            for (int i = 0; i < N2; i++)
            begin
                l2_reg[i] <= (sfs_pkg::PROD_W+2)'(l1_reg[2*i])
                             + (sfs_pkg::PROD_W+2)'(l1_reg[2*i+1]);
            end
        end
        if (ctl.ld_l3)
        begin
            l3_reg <= sfs_pkg::ACC_W'(l2_reg[0]) + sfs_pkg::ACC_W'(l2_reg[1]);
        end
    end

    assign sum = l3_reg;

endmodule

/* design/symmetric_fir_saturating.sv */
// Top level: symmetric FIR filter with truncation and 16-bit saturation.
// Each sample passes through seven register stages (pre-add, partial products, product,
// three adder-tree levels, output), the first of which loads at the accepting edge.
// Throughput: one sample per cycle; every stage is pipelined and stalls only when full.
// The output register lets a new sample enter while a finished result waits.
// Reset clears the sample delay line and stage valid bits and loads default coefficients.
module symmetric_fir_saturating #(
    parameter int TAPS = 15
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  sfs_pkg::cidx_t           cfg_index,
    input  sfs_pkg::coef_t           cfg_data,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  sfs_pkg::sample_t         sample_in,
    output logic                     result_valid,
    input  logic                     result_ready,
    output sfs_pkg::out_t            filtered_sample,
    output logic                     clipped
);

    // Symmetric taps fold into pairs; an odd count leaves a center cell.
    localparam int NPAIRS = (TAPS + 1) / 2;
    localparam int NSTAGE = 7;

    sfs_pkg::coef_t     coef_reg [NPAIRS];
    sfs_pkg::sample_t   a_chain  [NPAIRS];
    sfs_pkg::sample_t   b_chain  [NPAIRS];
    sfs_pkg::prod_t     prod     [NPAIRS];
    sfs_pkg::acc_t      sum;

    logic [NSTAGE:1]    v_reg;
    logic [NSTAGE:1]    v_next;
    logic [NSTAGE:1]    ld;

    sfs_pkg::cell_ctl_t cell_ctl;
    sfs_pkg::tree_ctl_t tree_ctl;

    logic               sum_neg;
    logic               clip_hi;
    logic               clip_lo;
    sfs_pkg::acc_t      sum_adj;
    sfs_pkg::out_t      filtered_next;
    logic               clipped_next;
    sfs_pkg::out_t      filtered_reg;
    logic               clipped_reg;

    // Coefficient registers. Writes to indexes without a cell are dropped.
    generate
        for (genvar m = 0; m < NPAIRS; m++)
        begin : g_coef
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    coef_reg[m] <= sfs_pkg::COEF_RESET[m];
                end
                else if (cfg_we && (cfg_index == sfs_pkg::CIDX_W'(m)))
                begin
                    coef_reg[m] <= cfg_data;
                end
            end
        end
    endgenerate

    // Each stage loads when it is empty or when the stage after it also loads,
    // so bubbles collapse and the input keeps flowing past a waiting result.
    always_comb
    begin
        ld[NSTAGE] = !v_reg[NSTAGE] || result_ready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    always_comb
    begin
        v_next[1] = ld[1] ? sample_valid : v_reg[1];
        for (int i = 2; i <= NSTAGE; i++)
        begin
            v_next[i] = ld[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign sample_ready = ld[1];

    // The delay line moves only when a sample transaction completes.
    assign cell_ctl.shift   = sample_valid && sample_ready;
    assign cell_ctl.ld_pre  = ld[1];
    assign cell_ctl.ld_part = ld[2];
    assign cell_ctl.ld_prod = ld[3];
    assign tree_ctl.ld_l1   = ld[4];
    assign tree_ctl.ld_l2   = ld[5];
    assign tree_ctl.ld_l3   = ld[6];

    // Folded chain: cell m sees the newest sample of its pair on a_chain[m]
    // and keeps the oldest one; the older samples walk back along b_chain.
    assign a_chain[0] = sample_in;

    generate
        for (genvar m = 0; m < NPAIRS; m++)
        begin : g_cell
            if (m < NPAIRS - 1)
            begin : g_inner
                sfs_tap_cell #(
                    .SINGLE (1'b0)
                ) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (cell_ctl),
                    .coef  (coef_reg[m]),
                    .a_in  (a_chain[m]),
                    .b_in  (b_chain[m+1]),
                    .a_out (a_chain[m+1]),
                    .b_out (b_chain[m]),
                    .prod  (prod[m])
                );
            end
            else
            begin : g_last
                // The last cell turns the chain around: with an even tap count it
                // takes its own newest sample as the next oldest one; with an odd
                // count it is the center tap.
                sfs_tap_cell #(
                    .SINGLE ((TAPS % 2) == 1)
                ) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (cell_ctl),
                    .coef  (coef_reg[m]),
                    .a_in  (a_chain[m]),
                    .b_in  (a_chain[m]),
                    .a_out (),
                    .b_out (b_chain[m]),
                    .prod  (prod[m])
                );
            end
        end
    endgenerate

    sfs_sum_tree #(
        .NLEAF (NPAIRS)
    ) u_tree (
        .clk  (clk),
        .ctl  (tree_ctl),
        .prod (prod),
        .sum  (sum)
    );

    // Output stage. Truncation toward zero adds 255 to a negative sum before the
    // arithmetic shift; a sum inside the limits then always fits 16 bits.
    assign sum_neg       = sum[sfs_pkg::ACC_W-1];
    assign clip_hi       = sum > sfs_pkg::SUM_MAX;
    assign clip_lo       = sum < sfs_pkg::SUM_MIN;
    assign sum_adj       = sum_neg ? (sum + sfs_pkg::TRUNC_BIAS) : sum;
    assign clipped_next  = clip_hi || clip_lo;

    always_comb
    begin
        if (clip_hi)
        begin
            filtered_next = sfs_pkg::OUT_MAX;
        end
        else if (clip_lo)
        begin
            filtered_next = sfs_pkg::OUT_MIN;
        end
        else
        begin
            filtered_next = sum_adj[sfs_pkg::FRAC_W +: sfs_pkg::OUT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NSTAGE])
        begin
            filtered_reg <= filtered_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign result_valid    = v_reg[NSTAGE];
    assign filtered_sample = filtered_reg;
    assign clipped         = clipped_reg;

    // A clamped result must sit at one of the two rails.
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clipped) |->
            (filtered_sample == sfs_pkg::OUT_MAX || filtered_sample == sfs_pkg::OUT_MIN))
        else $error("clipped result is not at a rail");

    // The input stalls only when every stage holds a transaction.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (&v_reg))
        else $error("input stalled with a bubble in the pipeline");

    // The delay line holds still unless a sample transaction completed.
    a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(sample_valid && sample_ready) |=> $stable(b_chain[0]))
        else $error("delay line moved without a sample transaction");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the symmetric saturating FIR filter.
module tb;

    localparam int TAP_COUNT    = 15;
    localparam int PIPE_LATENCY = 7;

    // The exact sum carries 8 fraction bits; 80 bits hold any 15-term sum
    // of 32-bit by 36-bit products without overflow.
    typedef logic signed [79:0] wide_sum_t;

    // Exact sums at the clamp limits: 32767.0 and -32768.0.
    localparam wide_sum_t SUM_TOP    = 32767 * 256;
    localparam wide_sum_t SUM_BOTTOM = -32768 * 256;

    // Coefficient register map, one entry per symmetric tap pair and one for the middle tap.
    typedef enum logic [sfs_pkg::CIDX_W-1:0] {
        TAP_EDGE_0,
        TAP_PAIR_1,
        TAP_PAIR_2,
        TAP_PAIR_3,
        TAP_PAIR_4,
        TAP_PAIR_5,
        TAP_PAIR_6,
        TAP_MIDDLE_7
    } tap_reg_t;

    localparam sfs_pkg::coef_t COEF_TOP    = {1'b0, {(sfs_pkg::COEF_W-1){1'b1}}};
    localparam sfs_pkg::coef_t COEF_BOTTOM = {1'b1, {(sfs_pkg::COEF_W-1){1'b0}}};
    localparam sfs_pkg::sample_t SAMPLE_TOP    = 32'sh7fffffff;
    localparam sfs_pkg::sample_t SAMPLE_BOTTOM = 32'sh80000000;

    // One filter output as the block presents it.
    typedef struct packed {
        sfs_pkg::out_t value;
        logic          clip;
    } filter_out_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    sfs_pkg::cidx_t   cfg_index = '0;
    sfs_pkg::coef_t   cfg_data = '0;
    logic             sample_valid = 1'b0;
    logic             sample_ready;
    sfs_pkg::sample_t sample_in = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    sfs_pkg::out_t    filtered_sample;
    logic             clipped;

    // Our own copy of the coefficient registers and the sample delay line.
    sfs_pkg::coef_t   tap_coef [sfs_pkg::NUM_COEF];
    sfs_pkg::sample_t sample_history [TAP_COUNT-1];

    // Outputs predicted for accepted samples, oldest first.
    filter_out_t pending_outputs [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_cycles = 0;

    int samples_sent = 0;
    int outputs_checked = 0;
    int clipped_seen = 0;
    int mismatch_count = 0;
    int input_stall_cycles = 0;

    symmetric_fir_saturating #(
        .TAPS(TAP_COUNT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample_in(sample_in),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .filtered_sample(filtered_sample),
        .clipped(clipped)
    );

    always #5 clk = ~clk;

    // Filters one sample: forms the exact sum of products over the new sample
    // and the delay line, advances the delay line, then truncates the fraction
    // toward zero and clamps to 16 bits.
    function automatic filter_out_t filter_sample(input sfs_pkg::sample_t x);
        wide_sum_t   sum;
        wide_sum_t   term_a;
        wide_sum_t   term_b;
        wide_sum_t   mag;
        filter_out_t r;
        int          m;
        sum = '0;
        for (int k = 0; k < TAP_COUNT; k++)
        begin
            // Tap k shares its coefficient with its mirror tap.
            m = (k < TAP_COUNT - 1 - k) ? k : TAP_COUNT - 1 - k;
            term_a = (k == 0) ? x : sample_history[k-1];
            term_b = tap_coef[m];
            sum = sum + term_a * term_b;
        end
        for (int k = TAP_COUNT - 2; k > 0; k--)
        begin
            sample_history[k] = sample_history[k-1];
        end
        sample_history[0] = x;

        if (sum > SUM_TOP)
        begin
            r = '{sfs_pkg::OUT_MAX, 1'b1};
        end
        else if (sum < SUM_BOTTOM)
        begin
            r = '{sfs_pkg::OUT_MIN, 1'b1};
        end
        else
        begin
            // Truncation toward zero works on the magnitude.
            mag = (sum < 0) ? -sum : sum;
            mag = mag >>> sfs_pkg::FRAC_W;
            r.value = (sum < 0) ? sfs_pkg::out_t'(-mag) : sfs_pkg::out_t'(mag);
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // A sample of random width, so that small and full-scale values both
    // show up often; every bit still toggles over a run.
    function automatic sfs_pkg::sample_t random_sample();
        int                 bits;
        logic signed [31:0] r;
        bits = $urandom_range(32, 1);
        r = $urandom;
        return r >>> (32 - bits);
    endfunction

    function automatic sfs_pkg::coef_t random_coef(input int max_bits);
        int                 bits;
        logic signed [63:0] r;
        bits = $urandom_range(max_bits, 1);
        r = {$urandom, $urandom};
        return sfs_pkg::coef_t'(r >>> (64 - bits));
    endfunction

    // Offers one sample transaction, with random idle cycles in front of it,
    // and records the predicted output once the block takes it. Valid stays
    // high after acceptance so that back-to-back samples need no gap.
    task automatic send_sample(input sfs_pkg::sample_t s);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_in <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_outputs.push_back(filter_sample(s));
        samples_sent++;
    endtask

    // Stops offering samples and waits until every predicted output is back,
    // so that the coefficients can be changed safely.
    task automatic wait_idle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_outputs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_tap(input tap_reg_t idx, input sfs_pkg::coef_t value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tap_coef[idx] = value;
    endtask

    task automatic write_all_taps(input sfs_pkg::coef_t value);
        for (int i = 0; i < sfs_pkg::NUM_COEF; i++)
        begin
            write_tap(tap_reg_t'(i), value);
        end
    endtask

    // Right after reset the block must use its default coefficients.
    task automatic test_reset_defaults();
        send_sample(32'sd1);
        send_sample(-32'sd1);
        send_sample(32'sd2);
        wait_idle();
    endtask

    // With only the edge pair set to 1/256 and fewer than 14 samples seen,
    // the sum equals the new sample scaled by 2^-8. This places the sum right
    // at the clamp limits, just past them, and on both sides of zero to show
    // truncation toward zero.
    task automatic test_sum_boundaries();
        write_all_taps('0);
        write_tap(TAP_EDGE_0, 36'sd1);
        send_sample(32'sd8388352);     // exactly 32767.0, passes
        send_sample(32'sd8388353);     // a hair above the top, clamps
        send_sample(32'sd8388480);     // 32767.5, clamps
        send_sample(-32'sd8388608);    // exactly -32768.0, passes
        send_sample(-32'sd8388609);    // just below -32768.0, clamps
        send_sample(-32'sd257);        // -1.004 truncates to -1
        send_sample(-32'sd255);        // -0.996 truncates to 0
        send_sample(32'sd255);
        wait_idle();
    endtask

    // Full-scale samples against full-scale coefficients of both signs.
    task automatic test_extremes();
        write_all_taps(COEF_TOP);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOTTOM);
        wait_idle();
        write_all_taps(COEF_BOTTOM);
        send_sample(SAMPLE_TOP);
        send_sample(SAMPLE_BOTTOM);
        send_sample('0);
        wait_idle();
    endtask

    // The output side holds off for a long stretch while samples keep coming,
    // so the pipeline fills and the block must push back on its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off_cycles = 150;
        for (int i = 0; i < 40; i++)
        begin
            send_sample(random_sample());
        end
        wait_idle();
    endtask

    // One random phase: fresh coefficients (random up to coef_bits wide, or
    // the power-up set), then a stream of random samples under the given
    // idling pattern.
    task automatic run_random_phase(input int count, input int idle_pct, input int stall,
                                    input int coef_bits, input bit reset_taps);
        wait_idle();
        for (int i = 0; i < sfs_pkg::NUM_COEF; i++)
        begin
            write_tap(tap_reg_t'(i),
                      reset_taps ? sfs_pkg::COEF_RESET[i] : random_coef(coef_bits));
        end
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            // Now and then a full-scale sample, otherwise a random width.
            case ($urandom_range(15))
                0:       send_sample(SAMPLE_TOP);
                1:       send_sample(SAMPLE_BOTTOM);
                default: send_sample(random_sample());
            endcase
        end
        wait_idle();
    endtask

    // Output side: random stalls, or a counted hold-off when a test asks.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            result_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Compares every output transaction with the oldest prediction.
    always @(posedge clk)
    begin : check_outputs
        filter_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("unexpected output %0d clip %0b with no sample pending",
                             filtered_sample, clipped);
                end
            end
            else
            begin
                want = pending_outputs.pop_front();
                outputs_checked++;
                if (want.clip)
                begin
                    clipped_seen++;
                end
                if (filtered_sample !== want.value || clipped !== want.clip)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("output %0d mismatch: expected %0d clip %0b, got %0d clip %0b",
                                 outputs_checked, want.value, want.clip,
                                 filtered_sample, clipped);
                    end
                end
            end
        end
        if (rst_n && sample_valid && !sample_ready)
        begin
            input_stall_cycles++;
        end
    end

    initial
    begin : main_sequence
        int drain_cycles;
        tap_coef = sfs_pkg::COEF_RESET;
        foreach (sample_history[i])
        begin
            sample_history[i] = '0;
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_sum_boundaries();
        test_extremes();

        // Random phases cover each idling pattern and several coefficient ranges.
        run_random_phase(150, 0, 0, 12, 1'b0);
        test_backpressure();
        run_random_phase(150, 71, 0, 20, 1'b0);
        run_random_phase(150, 0, 71, 36, 1'b0);
        run_random_phase(150, 15, 15, 36, 1'b1);
        run_random_phase(150, 0, 0, 8, 1'b0);

        // Let anything still in flight come out, with a bound.
        @(negedge clk);
        sample_valid <= 1'b0;
        drain_cycles = 0;
        while (pending_outputs.size() != 0 && drain_cycles < 5000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (PIPE_LATENCY + 3) @(posedge clk);
        if (pending_outputs.size() != 0)
        begin
            mismatch_count++;
            $display("%0d predicted outputs never arrived", pending_outputs.size());
        end

        $display("Filtered %0d samples and checked %0d outputs, %0d of them clamped.",
                 samples_sent, outputs_checked, clipped_seen);
        $display("Input was pushed back for %0d cycles; %0d mismatches in total.",
                 input_stall_cycles, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
